FILE: rtl/blcm_pkg.sv
package blcm_pkg;

  localparam int ADC_BITS = 12;
  localparam int MV_BITS = 16;
  localparam int CODE_BITS = 3;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [1:0] CRIT_LIMIT = 2'd2;
  localparam logic [1:0] COUNT_MAX = 2'd3;

  typedef enum logic [1:0] {
    GRADE_LOW  = 2'd0,
    GRADE_MID  = 2'd1,
    GRADE_HIGH = 2'd2
  } grade_t;

  typedef enum logic [1:0] {
    LED_OFF    = 2'd0,
    LED_RED    = 2'd1,
    LED_YELLOW = 2'd2,
    LED_GREEN  = 2'd3
  } led_t;

  typedef enum logic [2:0] {
    ST_CHECKING  = 3'd0,
    ST_SUSPENDED = 3'd1,
    ST_FULL      = 3'd2,
    ST_CHARGING  = 3'd3,
    ST_BAD       = 3'd4,
    ST_UNKNOWN   = 3'd5,
    ST_ERROR     = 3'd6
  } status_t;

  typedef enum logic [CODE_BITS-1:0] {
    CHG_SUSPENDED = 3'd0,
    CHG_FULL      = 3'd1,
    CHG_PRECOND   = 3'd2,
    CHG_BAD       = 3'd3,
    CHG_UNKNOWN   = 3'd4
  } charger_code_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MID_FALL   = 8'd0,
    REG_LOW_RISE   = 8'd1,
    REG_HIGH_FALL  = 8'd2,
    REG_MID_RISE   = 8'd3,
    REG_CUTOFF     = 8'd4,
    REG_ERR_MV_HI  = 8'd5,
    REG_ERR_MV_LO  = 8'd6,
    REG_AUTO_STOP  = 8'd7
  } cfg_reg_t;

endpackage

FILE: rtl/blcm_ifs.sv
interface blcm_in_if;
  logic                              valid;
  logic                              ready;
  logic [blcm_pkg::ADC_BITS-1:0]     adc_sample;
  logic [blcm_pkg::MV_BITS-1:0]      battery_mv;
  logic [blcm_pkg::CODE_BITS-1:0]    charger_code;
  logic                              is_docked;
  logic                              is_sensing;

  modport source (output valid, adc_sample, battery_mv, charger_code, is_docked, is_sensing,
                  input ready);
  modport sink (input valid, adc_sample, battery_mv, charger_code, is_docked, is_sensing,
                output ready);
  modport monitor (input valid, ready, adc_sample, battery_mv, charger_code, is_docked,
                   is_sensing);
endinterface

interface blcm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] charge_grade;
  logic [1:0] grade_led;
  logic [2:0] charge_status;
  logic [1:0] charge_led;
  logic       charge_led_flash;
  logic       battery_critical;
  logic       stop_request;

  modport source (output valid, charge_grade, grade_led, charge_status, charge_led,
                  charge_led_flash, battery_critical, stop_request, input ready);
  modport sink (input valid, charge_grade, grade_led, charge_status, charge_led,
                charge_led_flash, battery_critical, stop_request, output ready);
  modport monitor (input valid, ready, charge_grade, grade_led, charge_status, charge_led,
                   charge_led_flash, battery_critical, stop_request);
endinterface

interface blcm_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [blcm_pkg::CFG_IDX_BITS-1:0]    index;
  logic [blcm_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/battery_level_charge_monitor_top.sv
// channel  | role   | payload
// in_chan  | sink   | adc_sample, battery_mv, charger_code, is_docked, is_sensing
// out_chan | source | charge_grade, grade_led, charge_status, charge_led, charge_led_flash,
//          |        | battery_critical, stop_request
// cfg_chan | sink   | index, data (register write, always ready)
//
// one item per cycle sustained while out_chan is not stalled; an accepted input reaches out_chan
// through the input register, then the result register, with the decision logic between them
// synchronous active-low reset restores register defaults, mid grade, led off, count clear
// a stalled result holds while the input register still takes one more item
// config writes are taken in any cycle, one per cycle
module battery_level_charge_monitor_top (
  input  logic           clk,
  input  logic           rst_n,
  blcm_in_if.sink        in_chan,
  blcm_out_if.source     out_chan,
  blcm_cfg_if.sink       cfg_chan
);

  logic [blcm_pkg::ADC_BITS-1:0] mid_fall_r;
  logic [blcm_pkg::ADC_BITS-1:0] low_rise_r;
  logic [blcm_pkg::ADC_BITS-1:0] high_fall_r;
  logic [blcm_pkg::ADC_BITS-1:0] mid_rise_r;
  logic [blcm_pkg::ADC_BITS-1:0] cutoff_r;
  logic [blcm_pkg::MV_BITS-1:0]  err_mv_hi_r;
  logic [blcm_pkg::MV_BITS-1:0]  err_mv_lo_r;
  logic                          auto_stop_r;

  logic                             in_v_r;
  logic [blcm_pkg::ADC_BITS-1:0]    adc_r;
  logic [blcm_pkg::MV_BITS-1:0]     mv_r;
  logic [blcm_pkg::CODE_BITS-1:0]   code_r;
  logic                             docked_r;
  logic                             sensing_r;

  blcm_pkg::grade_t grade_r, grade_nxt;
  blcm_pkg::led_t   led_r, led_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             crit_r, crit_nxt;

  blcm_pkg::status_t status_nxt;
  logic              flash_nxt;
  logic              stop_nxt;

  logic                 out_v_r;
  blcm_pkg::grade_t     o_grade_r;
  blcm_pkg::led_t       o_gled_r;
  blcm_pkg::status_t    o_status_r;
  blcm_pkg::led_t       o_cled_r;
  logic                 o_flash_r;
  logic                 o_crit_r;
  logic                 o_stop_r;

  logic [blcm_pkg::ADC_BITS-1:0] low_edge;
  logic [blcm_pkg::ADC_BITS-1:0] high_edge;
  blcm_pkg::led_t                gled_nxt;
  logic                          counted;
  logic                          move;

  assign move = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || move;
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    unique case (grade_r)
      blcm_pkg::GRADE_LOW: begin
        low_edge  = low_rise_r;
        high_edge = mid_rise_r;
      end
      blcm_pkg::GRADE_MID: begin
        low_edge  = mid_fall_r;
        high_edge = mid_rise_r;
      end
      default: begin
        low_edge  = mid_fall_r;
        high_edge = high_fall_r;
      end
    endcase
    if (adc_r < low_edge) begin
      grade_nxt = blcm_pkg::GRADE_LOW;
    end else if (adc_r < high_edge) begin
      grade_nxt = blcm_pkg::GRADE_MID;
    end else begin
      grade_nxt = blcm_pkg::GRADE_HIGH;
    end
    unique case (grade_nxt)
      blcm_pkg::GRADE_MID:  gled_nxt = blcm_pkg::LED_YELLOW;
      blcm_pkg::GRADE_HIGH: gled_nxt = blcm_pkg::LED_GREEN;
      default:              gled_nxt = blcm_pkg::LED_RED;
    endcase
  end

  always_comb begin
    if (mv_r > err_mv_hi_r) begin
      status_nxt = blcm_pkg::ST_CHECKING;
    end else begin
      unique case (code_r)
        blcm_pkg::CHG_SUSPENDED:
          status_nxt = (mv_r <= err_mv_lo_r) ? blcm_pkg::ST_BAD : blcm_pkg::ST_SUSPENDED;
        blcm_pkg::CHG_FULL:    status_nxt = blcm_pkg::ST_FULL;
        blcm_pkg::CHG_PRECOND: status_nxt = blcm_pkg::ST_CHARGING;
        blcm_pkg::CHG_BAD:     status_nxt = blcm_pkg::ST_BAD;
        blcm_pkg::CHG_UNKNOWN: status_nxt = blcm_pkg::ST_UNKNOWN;
        default:               status_nxt = blcm_pkg::ST_ERROR;
      endcase
    end
    led_nxt   = led_r;
    flash_nxt = 1'b0;
    if (docked_r) begin
      case (status_nxt) inside
        blcm_pkg::ST_SUSPENDED: led_nxt = blcm_pkg::LED_YELLOW;
        blcm_pkg::ST_UNKNOWN, blcm_pkg::ST_BAD, blcm_pkg::ST_ERROR: begin
          led_nxt   = blcm_pkg::LED_RED;
          flash_nxt = 1'b1;
        end
        blcm_pkg::ST_FULL:      led_nxt = blcm_pkg::LED_GREEN;
        default:                led_nxt = blcm_pkg::LED_RED;
      endcase
    end
  end

  always_comb begin
    counted   = auto_stop_r && (adc_r < cutoff_r);
    count_nxt = count_r;
    crit_nxt  = crit_r;
    stop_nxt  = 1'b0;
    if (counted) begin
      if (count_r != blcm_pkg::COUNT_MAX) begin
        count_nxt = count_r + 2'd1;
      end
      if (count_nxt > blcm_pkg::CRIT_LIMIT) begin
        crit_nxt = 1'b1;
      end
      stop_nxt = crit_nxt && sensing_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_fall_r  <= blcm_pkg::ADC_BITS'(2450);
      low_rise_r  <= blcm_pkg::ADC_BITS'(2500);
      high_fall_r <= blcm_pkg::ADC_BITS'(2600);
      mid_rise_r  <= blcm_pkg::ADC_BITS'(2650);
      cutoff_r    <= blcm_pkg::ADC_BITS'(2400);
      err_mv_hi_r <= blcm_pkg::MV_BITS'(4500);
      err_mv_lo_r <= blcm_pkg::MV_BITS'(3000);
      auto_stop_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        blcm_pkg::REG_MID_FALL:  mid_fall_r  <= cfg_chan.data[blcm_pkg::ADC_BITS-1:0];
        blcm_pkg::REG_LOW_RISE:  low_rise_r  <= cfg_chan.data[blcm_pkg::ADC_BITS-1:0];
        blcm_pkg::REG_HIGH_FALL: high_fall_r <= cfg_chan.data[blcm_pkg::ADC_BITS-1:0];
        blcm_pkg::REG_MID_RISE:  mid_rise_r  <= cfg_chan.data[blcm_pkg::ADC_BITS-1:0];
        blcm_pkg::REG_CUTOFF:    cutoff_r    <= cfg_chan.data[blcm_pkg::ADC_BITS-1:0];
        blcm_pkg::REG_ERR_MV_HI: err_mv_hi_r <= cfg_chan.data[blcm_pkg::MV_BITS-1:0];
        blcm_pkg::REG_ERR_MV_LO: err_mv_lo_r <= cfg_chan.data[blcm_pkg::MV_BITS-1:0];
        blcm_pkg::REG_AUTO_STOP: auto_stop_r <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      grade_r <= blcm_pkg::GRADE_MID;
      led_r   <= blcm_pkg::LED_OFF;
      count_r <= 2'd0;
      crit_r  <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        in_v_r <= 1'b1;
      end else if (move) begin
        in_v_r <= 1'b0;
      end
      if (move) begin
        out_v_r <= 1'b1;
        grade_r <= grade_nxt;
        led_r   <= led_nxt;
        count_r <= count_nxt;
        crit_r  <= crit_nxt;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      adc_r     <= in_chan.adc_sample;
      mv_r      <= in_chan.battery_mv;
      code_r    <= in_chan.charger_code;
      docked_r  <= in_chan.is_docked;
      sensing_r <= in_chan.is_sensing;
    end
    if (move) begin
      o_grade_r  <= grade_nxt;
      o_gled_r   <= gled_nxt;
      o_status_r <= status_nxt;
      o_cled_r   <= led_nxt;
      o_flash_r  <= flash_nxt;
      o_crit_r   <= crit_nxt;
      o_stop_r   <= stop_nxt;
    end
  end

  assign out_chan.valid            = out_v_r;
  assign out_chan.charge_grade     = o_grade_r;
  assign out_chan.grade_led        = o_gled_r;
  assign out_chan.charge_status    = o_status_r;
  assign out_chan.charge_led       = o_cled_r;
  assign out_chan.charge_led_flash = o_flash_r;
  assign out_chan.battery_critical = o_crit_r;
  assign out_chan.stop_request     = o_stop_r;

endmodule

FILE: rtl/blcm_checker.sv
module blcm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_charge_grade,
  input logic [2:0] out_charge_status,
  input logic [1:0] out_charge_led,
  input logic       out_charge_led_flash,
  input logic       out_battery_critical,
  input logic       out_stop_request
);

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_charge_grade)
      && $stable(out_charge_status) && $stable(out_battery_critical))
    else $error("result item changed while stalled");

  a_critical_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_battery_critical |=> !out_valid
      || out_battery_critical)
    else $error("critical latch cleared without reset");

  a_stop_needs_critical: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_request |-> out_battery_critical)
    else $error("stop request without critical latch");

  a_flash_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_charge_led_flash |->
      out_charge_led == blcm_pkg::LED_RED
      && (out_charge_status == blcm_pkg::ST_BAD
        || out_charge_status == blcm_pkg::ST_UNKNOWN
        || out_charge_status == blcm_pkg::ST_ERROR))
    else $error("flash without a fault status on red");

endmodule

bind battery_level_charge_monitor_top blcm_checker u_blcm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_chan.valid),
  .out_ready            (out_chan.ready),
  .out_charge_grade     (out_chan.charge_grade),
  .out_charge_status    (out_chan.charge_status),
  .out_charge_led       (out_chan.charge_led),
  .out_charge_led_flash (out_chan.charge_led_flash),
  .out_battery_critical (out_chan.battery_critical),
  .out_stop_request     (out_chan.stop_request)
);
